[rtl/core/lexeme_token_classifier_defines.svh]
// Assertion macros used by the lexeme token classifier checker.
`ifndef LEXEME_TOKEN_CLASSIFIER_DEFINES_SVH
`define LEXEME_TOKEN_CLASSIFIER_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define LTC_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lexeme token classifier check failed");

// Next-cycle implication, sampled on clk and disabled during reset.
`define LTC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lexeme token classifier check failed");

`endif

[rtl/core/ltc_pkg.sv]
// Types, constants and lookup functions of the lexeme token classifier.
package ltc_pkg;

  localparam int unsigned WordCount = 16;
  localparam logic [6:0] CountMax = 7'd127;
  localparam logic [6:0] NumDigits = 7'd10;
  localparam logic [7:0] CharZero = 8'h30;
  localparam logic [7:0] CharNine = 8'h39;
  localparam logic [7:0] CharUpperA = 8'h41;
  localparam logic [7:0] CharUpperZ = 8'h5A;
  localparam logic [7:0] CharLowerA = 8'h61;
  localparam logic [7:0] CharLowerZ = 8'h7A;

  typedef enum logic [2:0] {
    CLS_INVALID,
    CLS_TYPENAME,
    CLS_BOOL_VALUE,
    CLS_BOOL_OP,
    CLS_KEYWORD,
    CLS_NUMBER,
    CLS_IDENT
  } class_t;

  typedef enum logic [1:0] {
    CMP_EQUAL,
    CMP_LESS,
    CMP_GREATER
  } cmp_t;

  // Running lexeme state, as held between characters.
  typedef struct packed {
    logic [WordCount-1:0] live;
    logic [6:0]           count;
    logic                 all_digits;
    logic                 lead_zero;
    cmp_t                 cmp;
    logic                 ident_ok;
  } scan_t;

  localparam scan_t ScanClear = '{
    live:       '1,
    count:      7'd0,
    all_digits: 1'b1,
    lead_zero:  1'b0,
    cmp:        CMP_EQUAL,
    ident_ok:   1'b1
  };

  // Fixed words, right-justified, first character in the highest used byte.
  localparam logic [63:0] WordText [WordCount] = '{
    64'("integer"), 64'("boolean"), 64'("true"), 64'("false"),
    64'("and"), 64'("or"), 64'("not"), 64'("if"),
    64'("then"), 64'("else"), 64'("print"), 64'("program"),
    64'("function"), 64'("return"), 64'("begin"), 64'("end")
  };

  localparam logic [3:0] WordLen [WordCount] = '{
    4'd7, 4'd7, 4'd4, 4'd5, 4'd3, 4'd2, 4'd3, 4'd2,
    4'd4, 4'd4, 4'd5, 4'd7, 4'd8, 4'd6, 4'd5, 4'd3
  };

  localparam class_t WordClass [WordCount] = '{
    CLS_TYPENAME, CLS_TYPENAME, CLS_BOOL_VALUE, CLS_BOOL_VALUE,
    CLS_BOOL_OP, CLS_BOOL_OP, CLS_BOOL_OP, CLS_KEYWORD,
    CLS_KEYWORD, CLS_KEYWORD, CLS_KEYWORD, CLS_KEYWORD,
    CLS_KEYWORD, CLS_KEYWORD, CLS_KEYWORD, CLS_KEYWORD
  };

  // Largest 32-bit unsigned value as decimal text.
  localparam logic [79:0] LimitText = 80'("4294967295");

  // Character at position pos of fixed word w; pos must be below its length.
  function automatic logic [7:0] word_char(input logic [3:0] w, input logic [2:0] pos);
    logic [63:0] text;
    logic [2:0]  sh;
    text = WordText[w];
    sh   = WordLen[w][2:0] - 3'd1 - pos;
    return text[{sh, 3'b000} +: 8];
  endfunction

  // Character at position pos of the limit text; pos must be below ten.
  function automatic logic [7:0] limit_char(input logic [3:0] pos);
    logic [3:0] sh;
    sh = 4'd9 - pos;
    return LimitText[{sh, 3'b000} +: 8];
  endfunction

endpackage

[rtl/core/ltc_scan.sv]
// Per-character state update: word match mask, length count and flags.
module ltc_scan (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            step,
  input  logic [7:0]      char_code,
  input  logic            last_char,
  output ltc_pkg::scan_t  scan_o
);

  ltc_pkg::scan_t scan_r;
  ltc_pkg::scan_t scan_nxt;
  logic [6:0]     pos;
  logic           digit;
  logic           alpha;
  logic [7:0]     lim;

  // Character classes.
  assign pos   = scan_r.count;
  assign digit = (char_code >= ltc_pkg::CharZero) && (char_code <= ltc_pkg::CharNine);
  assign alpha = ((char_code >= ltc_pkg::CharUpperA) && (char_code <= ltc_pkg::CharUpperZ)) ||
                 ((char_code >= ltc_pkg::CharLowerA) && (char_code <= ltc_pkg::CharLowerZ));
  assign lim   = ltc_pkg::limit_char(pos[3:0]);

  // State after this character.
  always_comb begin
    scan_nxt = scan_r;
    for (int w = 0; w < ltc_pkg::WordCount; w++) begin
      if (!(({3'b000, ltc_pkg::WordLen[w]} > pos) &&
            (char_code == ltc_pkg::word_char(4'(w), pos[2:0])))) begin
        scan_nxt.live[w] = 1'b0;
      end
    end
    scan_nxt.all_digits = scan_r.all_digits & digit;
    if ((pos == 7'd0) && (char_code == ltc_pkg::CharZero)) begin
      scan_nxt.lead_zero = 1'b1;
    end
    if ((scan_r.cmp == ltc_pkg::CMP_EQUAL) && (pos < ltc_pkg::NumDigits)) begin
      if (char_code < lim) begin
        scan_nxt.cmp = ltc_pkg::CMP_LESS;
      end else if (char_code > lim) begin
        scan_nxt.cmp = ltc_pkg::CMP_GREATER;
      end
    end
    if (pos == 7'd0) begin
      scan_nxt.ident_ok = alpha;
    end else if (!(alpha || digit)) begin
      scan_nxt.ident_ok = 1'b0;
    end
    scan_nxt.count = (pos == ltc_pkg::CountMax) ? pos : pos + 7'd1;
  end

  // Hold state between characters; clear it after the final one.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_r <= ltc_pkg::ScanClear;
    end else if (step) begin
      scan_r <= last_char ? ltc_pkg::ScanClear : scan_nxt;
    end
  end

  assign scan_o = scan_nxt;

endmodule

[rtl/core/ltc_decide.sv]
// Final classification of a lexeme from its completed scan state.
module ltc_decide (
  input  ltc_pkg::scan_t  scan_i,
  input  logic [6:0]      max_len,
  output ltc_pkg::class_t token_class
);

  logic is_word;
  logic is_number;

  always_comb begin
    token_class = ltc_pkg::CLS_INVALID;
    is_word     = 1'b0;
    // Lowest-numbered matching word wins, so scan from the top down.
    for (int w = ltc_pkg::WordCount - 1; w >= 0; w--) begin
      if (scan_i.live[w] && (scan_i.count == {3'b000, ltc_pkg::WordLen[w]})) begin
        token_class = ltc_pkg::WordClass[w];
        is_word     = 1'b1;
      end
    end
    is_number = scan_i.all_digits && (scan_i.count <= ltc_pkg::NumDigits) &&
                !((scan_i.count > 7'd1) && scan_i.lead_zero) &&
                !((scan_i.count == ltc_pkg::NumDigits) &&
                  (scan_i.cmp == ltc_pkg::CMP_GREATER));
    if (!is_word) begin
      if (is_number) begin
        token_class = ltc_pkg::CLS_NUMBER;
      end else if ((scan_i.count <= max_len) && scan_i.ident_ok) begin
        token_class = ltc_pkg::CLS_IDENT;
      end
    end
  end

endmodule

[rtl/core/lexeme_token_classifier.sv]
// Top level of the lexeme token classifier: input and result registers.
//
// Takes a lexeme one character per word on the input stream, in_tlast on its
// final character, and returns one result word with the lexeme's class for
// each final character (0 invalid, 1 type name, 2 boolean value, 3 boolean
// operator, 4 keyword, 5 number, 6 identifier). One character is accepted
// every cycle, except while a final character waits behind a stalled result
// word. The result word is registered as its final character leaves the
// input register. The rate is set by the update of the word match mask,
// length count and digit flags between the input and result registers. The
// identifier length limit (reset 32) is written through the cfg port; the
// user must write it only while no lexeme is in flight; it is not enforced.
module lexeme_token_classifier (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] char_code
  input  logic       in_tlast,   // last_char
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [2:0] token_class, [7:3] zero
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [6:0] cfg_data    // identifier length limit
);

  logic            in_valid_r;
  logic [7:0]      in_char_r;
  logic            in_last_r;
  logic            advance;
  logic [6:0]      max_len_r;
  logic            out_valid_r;
  ltc_pkg::class_t out_class_r;
  ltc_pkg::scan_t  scan;
  ltc_pkg::class_t cls;

  // A held character moves on unless it would produce a result into a full,
  // stalled result register.
  assign advance   = in_valid_r && (!in_last_r || !out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;
  assign cfg_ready = 1'b1;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_char_r <= in_tdata;
      in_last_r <= in_tlast;
    end
  end

  // Identifier length limit.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= 7'd32;
    end else if (cfg_valid && cfg_ready) begin
      max_len_r <= cfg_data;
    end
  end

  ltc_scan u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (advance),
    .char_code (in_char_r),
    .last_char (in_last_r),
    .scan_o    (scan)
  );

  ltc_decide u_decide (
    .scan_i      (scan),
    .max_len     (max_len_r),
    .token_class (cls)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && in_last_r) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_last_r) begin
      out_class_r <= cls;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b00000, out_class_r};

endmodule

[rtl/core/ltc_checker.sv]
// Port-level assertions for the lexeme token classifier, bound to the top.
`include "lexeme_token_classifier_defines.svh"

module ltc_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tready,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata
);

  // A result carries a defined class code and zero padding.
  `LTC_ASSERT_SAME(a_class_code, out_tvalid, out_tdata[2:0] != 3'd7)
  `LTC_ASSERT_SAME(a_pad_zero, out_tvalid, out_tdata[7:3] == 5'd0)
  // With the result register empty, the input side never stalls.
  `LTC_ASSERT_SAME(a_no_stall_when_empty, !out_tvalid, in_tready)
  // A stalled result holds its word.
  `LTC_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))

endmodule

bind lexeme_token_classifier ltc_checker u_ltc_checker (.*);

[bench/testbench.sv]
// Self-checking bench for the lexeme token classifier: random lexemes in, classes checked.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // One character word as it travels on the input stream.
  typedef struct packed {
    logic [7:0] code;
    logic       last;
  } char_word_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = '0;   // [7:0] char_code
  logic       in_tlast = 1'b0; // last_char
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;       // [2:0] token_class, [7:3] zero
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [6:0] cfg_data = '0;   // identifier length limit

  lexeme_token_classifier dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  // Fixed words and the class each one yields, in priority order.
  string  word_list [16] = '{
    "integer", "boolean", "true", "false", "and", "or", "not", "if",
    "then", "else", "print", "program", "function", "return", "begin", "end"
  };
  ltc_pkg::class_t word_kind [16] = '{
    ltc_pkg::CLS_TYPENAME, ltc_pkg::CLS_TYPENAME,
    ltc_pkg::CLS_BOOL_VALUE, ltc_pkg::CLS_BOOL_VALUE,
    ltc_pkg::CLS_BOOL_OP, ltc_pkg::CLS_BOOL_OP, ltc_pkg::CLS_BOOL_OP,
    ltc_pkg::CLS_KEYWORD, ltc_pkg::CLS_KEYWORD, ltc_pkg::CLS_KEYWORD,
    ltc_pkg::CLS_KEYWORD, ltc_pkg::CLS_KEYWORD, ltc_pkg::CLS_KEYWORD,
    ltc_pkg::CLS_KEYWORD, ltc_pkg::CLS_KEYWORD, ltc_pkg::CLS_KEYWORD
  };
  string  u32_max_text = "4294967295";

  char_word_t      char_backlog [$];
  ltc_pkg::class_t pending_classes [$];
  logic [7:0]      lex_buf [$];
  char_word_t      next_char;
  ltc_pkg::class_t want_class;
  logic [6:0]      ident_limit = 7'd32;
  int              fail_count = 0;
  int              send_wait = 0;
  int              recv_wait = 0;
  bit              idle_on = 1'b1;
  bit              pressure_go = 1'b0;
  logic            rx_hold = 1'b0;

  // Running scan state of the lexeme being received.
  logic [15:0]   sc_live;
  logic [6:0]    sc_count;
  logic          sc_digits;
  logic          sc_lead0;
  ltc_pkg::cmp_t sc_cmp;
  logic          sc_ident;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Gap length: mostly none, some short, a few long.
  function automatic int idle_len();
    int r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic clear_scan();
    sc_live   = '1;
    sc_count  = 7'd0;
    sc_digits = 1'b1;
    sc_lead0  = 1'b0;
    sc_cmp    = ltc_pkg::CMP_EQUAL;
    sc_ident  = 1'b1;
  endtask

  // Fold one accepted character into the scan state; on the final one,
  // queue the class the lexeme should get.
  task automatic scan_char(input logic [7:0] ch, input logic last);
    int              pos;
    int              w;
    logic            is_digit;
    logic            is_alpha;
    logic            found;
    logic [7:0]      lim_ch;
    logic [6:0]      len;
    ltc_pkg::class_t cls;
    pos      = sc_count;
    is_digit = (ch >= "0") && (ch <= "9");
    is_alpha = ((ch >= "A") && (ch <= "Z")) || ((ch >= "a") && (ch <= "z"));
    for (w = 0; w < 16; w++) begin
      if (pos >= word_list[w].len()) sc_live[w] = 1'b0;
      else if (ch != 8'(word_list[w][pos])) sc_live[w] = 1'b0;
    end
    if (!is_digit) sc_digits = 1'b0;
    if (pos == 0 && ch == "0") sc_lead0 = 1'b1;
    // Running compare against the largest 32-bit value.
    if (sc_cmp == ltc_pkg::CMP_EQUAL && pos < 10) begin
      lim_ch = 8'(u32_max_text[pos]);
      if (ch < lim_ch) sc_cmp = ltc_pkg::CMP_LESS;
      else if (ch > lim_ch) sc_cmp = ltc_pkg::CMP_GREATER;
    end
    if (pos == 0) sc_ident = is_alpha;
    else if (!(is_alpha || is_digit)) sc_ident = 1'b0;
    if (sc_count != 7'd127) sc_count = sc_count + 7'd1;
    if (last) begin
      len   = sc_count;
      cls   = ltc_pkg::CLS_INVALID;
      found = 1'b0;
      for (w = 0; w < 16; w++) begin
        if (!found && sc_live[w] && int'(len) == word_list[w].len()) begin
          cls   = word_kind[w];
          found = 1'b1;
        end
      end
      if (!found) begin
        if (sc_digits && len <= 7'd10 && !(len > 7'd1 && sc_lead0) &&
            !(len == 7'd10 && sc_cmp == ltc_pkg::CMP_GREATER))
          cls = ltc_pkg::CLS_NUMBER;
        else if (len <= ident_limit && sc_ident)
          cls = ltc_pkg::CLS_IDENT;
      end
      pending_classes.push_back(cls);
      clear_scan();
    end
  endtask

  // Input driver: presents queued characters with random gaps.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
      in_tlast  <= 1'b0;
      send_wait = 0;
      clear_scan();
    end else begin
      if (in_tvalid && in_tready) scan_char(in_tdata, in_tlast);
      if (!in_tvalid || in_tready) begin
        if (send_wait > 0) begin
          send_wait--;
          in_tvalid <= 1'b0;
        end else if (char_backlog.size() > 0) begin
          next_char = char_backlog.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= next_char.code;
          in_tlast  <= next_char.last;
          send_wait = idle_len();
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: random back-pressure and in-order comparison.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      recv_wait = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (pending_classes.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("[%0t] unexpected result word 0x%02h", $realtime, out_tdata);
        end else begin
          want_class = pending_classes.pop_front();
          if (out_tdata !== {5'd0, want_class}) begin
            fail_count++;
            if (fail_count <= 10)
              $display("[%0t] class mismatch: expected %0d (%s), got 0x%02h",
                       $realtime, want_class, want_class.name(), out_tdata);
          end
        end
      end
      if (rx_hold) begin
        out_tready <= 1'b0;
      end else if (recv_wait > 0) begin
        recv_wait--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        recv_wait = idle_len();
      end
    end
  end

  // Long receiver hold-off, so the block fills and stalls its input.
  initial begin
    wait (pressure_go);
    @(posedge clk);
    rx_hold <= 1'b1;
    repeat (400) @(posedge clk);
    rx_hold <= 1'b0;
  end

  // Move the buffered lexeme onto the backlog, flagging its last character.
  task automatic emit_lexeme();
    int i;
    for (i = 0; i < lex_buf.size(); i++)
      char_backlog.push_back('{code: lex_buf[i], last: (i == lex_buf.size() - 1)});
    lex_buf.delete();
  endtask

  task automatic add_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) lex_buf.push_back(8'(s[i]));
  endtask

  task automatic lexeme(input string s);
    add_text(s);
    emit_lexeme();
  endtask

  function automatic logic [7:0] rand_letter();
    int r;
    r = $urandom_range(0, 51);
    return (r < 26) ? 8'("A") + 8'(r) : 8'("a") + 8'(r - 26);
  endfunction

  function automatic logic [7:0] rand_alnum();
    int r;
    r = $urandom_range(0, 61);
    return (r < 10) ? 8'("0") + 8'(r) : rand_letter();
  endfunction

  function automatic logic [7:0] rand_digit();
    return 8'("0") + 8'($urandom_range(0, 9));
  endfunction

  // Identifier of n characters; now and then one character is spoiled.
  task automatic make_ident(input int n);
    int i;
    lex_buf.push_back(rand_letter());
    for (i = 1; i < n; i++) lex_buf.push_back(rand_alnum());
    if ($urandom_range(0, 9) == 0)
      lex_buf[$urandom_range(0, n - 1)] = 8'($urandom_range(0, 255));
    emit_lexeme();
  endtask

  // One random lexeme: mostly well-formed words, numbers and identifiers.
  task automatic random_lexeme();
    int k;
    int m;
    int n;
    int i;
    k = $urandom_range(0, 99);
    if (k < 25) begin
      // Fixed word, sometimes extended, cut short or altered.
      add_text(word_list[$urandom_range(0, 15)]);
      m = $urandom_range(0, 7);
      if (m == 0) lex_buf.push_back(rand_alnum());
      else if (m == 1 && lex_buf.size() > 1) void'(lex_buf.pop_back());
      else if (m == 2) lex_buf[$urandom_range(0, lex_buf.size() - 1)] = rand_letter();
      emit_lexeme();
    end else if (k < 50) begin
      m = $urandom_range(0, 5);
      if (m < 2) begin
        add_text($sformatf("%0d", $urandom));
      end else if (m == 2) begin
        add_text($sformatf("%0d", $urandom_range(0, 999)));
      end else if (m == 3) begin
        // Ten digits sharing a prefix with the 32-bit limit.
        n = $urandom_range(0, 10);
        for (i = 0; i < 10; i++)
          lex_buf.push_back(i < n ? 8'(u32_max_text[i]) : rand_digit());
      end else if (m == 4) begin
        lex_buf.push_back("0");
        n = $urandom_range(0, 4);
        for (i = 0; i < n; i++) lex_buf.push_back(rand_digit());
      end else begin
        n = $urandom_range(11, 13);
        for (i = 0; i < n; i++) lex_buf.push_back(rand_digit());
      end
      emit_lexeme();
    end else if (k < 85) begin
      m = $urandom_range(0, 39);
      if (m == 0) n = $urandom_range(120, 140);
      else if (m < 6) n = int'(ident_limit) + $urandom_range(0, 2) - 1;
      else n = $urandom_range(1, 12);
      if (n < 1) n = 1;
      make_ident(n);
    end else begin
      // Raw bytes across the whole character range.
      n = $urandom_range(1, 5);
      for (i = 0; i < n; i++) lex_buf.push_back(8'($urandom_range(0, 255)));
      emit_lexeme();
    end
  endtask

  task automatic random_run(input int chars);
    int queued;
    queued = 0;
    while (queued < chars) begin
      queued += lex_buf.size();
      random_lexeme();
      queued = char_backlog.size() > queued ? char_backlog.size() : queued;
    end
  endtask

  // Wait until every character is taken and every class has come back.
  task automatic wait_drained();
    do @(posedge clk);
    while (char_backlog.size() != 0 || in_tvalid || pending_classes.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_limit(input logic [6:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    ident_limit = value;
  endtask

  // Stimulus: directed lexemes, then random phases over several limits.
  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    lexeme("integer");
    lexeme("true");
    lexeme("or");
    lexeme("function");
    lexeme("end");
    lexeme("ends");
    lexeme("0");
    lexeme("00");
    lexeme("4294967295");
    lexeme("4294967296");
    lexeme("12345678901");
    lexeme("a");
    lexeme("Z9");
    lexeme("9Z");
    lexeme("@");
    lex_buf.push_back(8'h00);
    emit_lexeme();
    lex_buf.push_back(8'hFF);
    emit_lexeme();
    lex_buf.push_back("a");
    lex_buf.push_back(8'h80);
    emit_lexeme();
    random_run(300);
    wait_drained();

    // Shortest nonzero limit, with no idling on either side.
    write_limit(7'd1);
    idle_on = 1'b0;
    random_run(250);
    wait_drained();
    idle_on = 1'b1;

    // Upper limit of normal use, under a long receiver stall.
    write_limit(7'd100);
    pressure_go = 1'b1;
    random_run(250);
    wait_drained();

    // Zero limit rejects every identifier.
    write_limit(7'd0);
    lexeme("x");
    random_run(200);
    wait_drained();

    // Largest limit with lexemes around and past the saturating count.
    write_limit(7'd127);
    make_ident(126);
    make_ident(127);
    make_ident(128);
    make_ident(140);
    lexeme("if");
    random_run(250);
    wait_drained();

    write_limit(7'($urandom_range(2, 126)));
    random_run(120);
    wait_drained();
    repeat (8) @(posedge clk);

    if (fail_count == 0 && pending_classes.size() == 0)
      $display("** lexeme_token_classifier: PASSED **");
    else
      $display("** lexeme_token_classifier: FAILED **");
    $finish;
  end

  // Timeout.
  initial begin
    #20_000_000;
    $display("** lexeme_token_classifier: FAILED **");
    $finish;
  end

endmodule

[files.f]
+incdir+rtl/core
rtl/core/ltc_pkg.sv
rtl/core/ltc_scan.sv
rtl/core/ltc_decide.sv
rtl/core/lexeme_token_classifier.sv
rtl/core/ltc_checker.sv
bench/testbench.sv
